[hw/rtl/gtts_pkg.sv]
// Shared types and constants for the GPU timing track statistics block.
// No dependencies; imported by gpu_timing_track_stats.
package gtts_pkg;

  localparam int TIME_W  = 16;
  localparam int FRAME_W = 32;
  localparam int PIDX_W  = 5;

  // k = n*95/100 as n * (95 * ceil(2^19/100)) >> 19, exact for n*95 < 2^15
  localparam int P95_NUM   = 95;
  localparam int P95_RECIP = 5243;
  localparam int P95_SHIFT = 19;

  typedef enum logic [1:0] {
    ST_PENDING      = 2'd0,
    ST_VALID        = 2'd1,
    ST_UNAVAILABLE  = 2'd2,
    ST_CPU_FALLBACK = 2'd3
  } track_status_t;

endpackage

[hw/rtl/gpu_timing_track_stats.sv]
// GPU timing track statistics: per-pass timing ring, status and window stats.
// Depends on gtts_pkg.
// Without statistics a result passes through S_UPD and S_FIN only; with a window of
//   n samples it takes 16 radix passes over the timing memory's single read port,
//   then a bit-serial divider for the mean.
// Beats are handled one at a time; the next beat is taken the cycle
//   after the result enters the output register, which waits while out_stall holds.
//   Reset (rst_n low, synchronous) sets every track to unavailable with an empty
//   window; the timing memory needs no clearing.
module gpu_timing_track_stats #(
  parameter int NUM_PASSES     = 20,
  parameter int WINDOW         = 64,
  parameter int OVERAGE_FRAMES = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [NUM_PASSES-1:0]             cfg_disabled_passes,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gtts_pkg::PIDX_W-1:0]       in_pass_index,
  input  logic                              in_timer_supported,
  input  logic                              in_result_ready,
  input  logic [gtts_pkg::FRAME_W-1:0]      in_result_frame,
  input  logic [gtts_pkg::TIME_W-1:0]       in_result_time,
  input  logic [gtts_pkg::FRAME_W-1:0]      in_current_frame,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gtts_pkg::track_status_t           out_track_status,
  output logic [gtts_pkg::TIME_W-1:0]       out_window_mean,
  output logic [gtts_pkg::TIME_W-1:0]       out_window_p95,
  output logic [gtts_pkg::FRAME_W-1:0]      out_accepted_frame,
  output logic [$clog2(WINDOW+1)-1:0]       out_samples_held
);
  import gtts_pkg::*;

  localparam int PIW   = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
  localparam int WIW   = $clog2(WINDOW);
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int SUM_W = TIME_W + FW;
  localparam int DCW   = $clog2(SUM_W + 1);
  localparam int BW    = $clog2(TIME_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_SCAN = 6'b000100,
    S_TAIL = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_PASSES-1:0] dis_r;
  logic [WIW-1:0]        pos_r   [NUM_PASSES];
  logic [FW-1:0]         fill_r  [NUM_PASSES];
  logic [FRAME_W-1:0]    last_r  [NUM_PASSES];
  track_status_t         stat_r  [NUM_PASSES];

  logic [TIME_W-1:0]     tmem [0:(1 << (PIW + WIW))-1];
  logic [TIME_W-1:0]     rd_data_r;
  logic                  rd_v_r;

  logic [PIDX_W-1:0]     pass_r;
  logic                  sup_r, rdy_r;
  logic [FRAME_W-1:0]    rframe_r, cur_r;
  logic [TIME_W-1:0]     rtime_r;

  track_status_t         rst_st_r;
  logic [FW-1:0]         n_r, k_r, cnt_r;
  logic [FRAME_W-1:0]    frame_o_r;
  logic                  rep_r;
  logic [WIW-1:0]        idx_r;
  logic [BW-1:0]         bit_r;
  logic [TIME_W-1:0]     prefix_r;
  logic [SUM_W-1:0]      dq_r;
  logic [FW:0]           rem_r;
  logic [DCW-1:0]        dcnt_r;

  logic                  out_valid_r;
  track_status_t         out_st_r;
  logic [TIME_W-1:0]     out_mean_r, out_p95_r;
  logic [FRAME_W-1:0]    out_frame_r;
  logic [FW-1:0]         out_fill_r;

  // update decode
  logic [PIW-1:0]        pidx;
  logic                  in_rng, take, upd_en;
  logic [FRAME_W-1:0]    age;
  track_status_t         st_new;
  logic [FW-1:0]         fill_new;
  logic [FRAME_W-1:0]    last_new;
  logic [WIW-1:0]        pos_new;
  logic [31:0]           k_full;
  logic [FW-1:0]         k_new;
  // radix select
  logic [16:0]           hi_wide;
  logic [TIME_W-1:0]     himask;
  logic                  hit;
  logic [FW-1:0]         ctot;
  logic [FW:0]           rem_sh;
  logic                  load_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign pidx      = pass_r[PIW-1:0];
  assign in_rng    = ({1'b0, pass_r} < (PIDX_W+1)'(NUM_PASSES));
  assign take      = rdy_r && (rframe_r > last_r[pidx]);
  assign upd_en    = in_rng && sup_r && !dis_r[pidx];
  assign age       = (cur_r >= last_r[pidx]) ? (cur_r - last_r[pidx]) : '0;

  always_comb begin
    st_new   = stat_r[pidx];
    fill_new = fill_r[pidx];
    last_new = last_r[pidx];
    pos_new  = pos_r[pidx];
    if (!sup_r) begin
      st_new = ST_CPU_FALLBACK;
    end else if (upd_en) begin
      if (take) begin
        pos_new  = (pos_r[pidx] == WIW'(WINDOW - 1)) ? '0 : pos_r[pidx] + 1'b1;
        fill_new = (fill_r[pidx] < FW'(WINDOW)) ? fill_r[pidx] + 1'b1 : fill_r[pidx];
        last_new = rframe_r;
        st_new   = ST_VALID;
      end else if (age >= FRAME_W'(OVERAGE_FRAMES)) begin
        st_new = ST_UNAVAILABLE;
      end else if (cur_r > last_r[pidx]) begin
        st_new = ST_PENDING;
      end
    end
  end

  assign k_full = (32'(fill_new) * 32'(P95_NUM * P95_RECIP)) >> P95_SHIFT;
  assign k_new  = (FW'(k_full) > fill_new - 1'b1) ? fill_new - 1'b1 : FW'(k_full);

  assign hi_wide = 17'h1FFFF << (5'(bit_r) + 5'd1);
  assign himask  = hi_wide[TIME_W-1:0];
  assign hit     = (((rd_data_r ^ prefix_r) & himask) == '0) && !rd_data_r[bit_r];
  assign ctot    = cnt_r + FW'(hit);
  assign rem_sh  = {rem_r[FW-1:0], dq_r[SUM_W-1]};
  assign load_out = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_UPD;
      S_UPD: begin
        if (in_rng && fill_new != '0 && (st_new == ST_VALID || st_new == ST_PENDING))
          state_nxt = S_SCAN;
        else
          state_nxt = S_FIN;
      end
      S_SCAN: if (idx_r == WIW'(n_r - 1'b1)) state_nxt = S_TAIL;
      S_TAIL: state_nxt = (bit_r == '0) ? S_DIV : S_SCAN;
      S_DIV:  if (dcnt_r == DCW'(SUM_W - 1)) state_nxt = S_FIN;
      S_FIN:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD && upd_en && take)
      tmem[{pidx, pos_r[pidx]}] <= rtime_r;
    rd_data_r <= tmem[{pidx, idx_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dis_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_PASSES; p++) begin
        pos_r[p]  <= '0;
        fill_r[p] <= '0;
        last_r[p] <= '0;
        stat_r[p] <= ST_UNAVAILABLE;
      end
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_SCAN);
      if (cfg_valid) dis_r <= cfg_disabled_passes;
      if (state_r == S_UPD && in_rng) begin
        stat_r[pidx] <= st_new;
        fill_r[pidx] <= fill_new;
        last_r[pidx] <= last_new;
        pos_r[pidx]  <= pos_new;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        pass_r   <= in_pass_index;
        sup_r    <= in_timer_supported;
        rdy_r    <= in_result_ready;
        rframe_r <= in_result_frame;
        rtime_r  <= in_result_time;
        cur_r    <= in_current_frame;
      end
      S_UPD: begin
        rst_st_r  <= in_rng ? st_new : ST_UNAVAILABLE;
        n_r       <= in_rng ? fill_new : '0;
        k_r       <= k_new;
        frame_o_r <= last_new;
        rep_r     <= in_rng && fill_new != '0 &&
                     (st_new == ST_VALID || st_new == ST_PENDING);
        idx_r     <= '0;
        bit_r     <= BW'(TIME_W - 1);
        cnt_r     <= '0;
        prefix_r  <= '0;
        dq_r      <= '0;
        rem_r     <= '0;
        dcnt_r    <= '0;
      end
      S_SCAN: begin
        if (idx_r != WIW'(n_r - 1'b1)) idx_r <= idx_r + 1'b1;
        if (rd_v_r) begin
          cnt_r <= ctot;
          if (bit_r == BW'(TIME_W - 1)) dq_r <= dq_r + SUM_W'(rd_data_r);
        end
      end
      S_TAIL: begin
        if (bit_r == BW'(TIME_W - 1)) dq_r <= dq_r + SUM_W'(rd_data_r);
        if (k_r >= ctot) begin
          prefix_r[bit_r] <= 1'b1;
          k_r             <= k_r - ctot;
        end
        cnt_r <= '0;
        idx_r <= '0;
        bit_r <= bit_r - 1'b1;
      end
      S_DIV: begin
        dcnt_r <= dcnt_r + 1'b1;
        if (rem_sh >= {1'b0, n_r}) begin
          rem_r <= rem_sh - {1'b0, n_r};
          dq_r  <= {dq_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dq_r  <= {dq_r[SUM_W-2:0], 1'b0};
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_st_r    <= rst_st_r;
          out_fill_r  <= n_r;
          out_mean_r  <= rep_r ? dq_r[TIME_W-1:0] : '0;
          out_p95_r   <= rep_r ? prefix_r : '0;
          out_frame_r <= rep_r ? frame_o_r : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_track_status   = out_st_r;
  assign out_window_mean    = out_mean_r;
  assign out_window_p95     = out_p95_r;
  assign out_accepted_frame = out_frame_r;
  assign out_samples_held   = out_fill_r;

endmodule
